### rtl/sge_pkg.sv
package sge_pkg;

  // fixed field types of the channels
  typedef logic [3:0]         cmd_t;
  typedef logic [3:0]         qubit_t;
  typedef logic [9:0]         index_t;
  typedef logic signed [15:0] q14_t;
  typedef logic [31:0]        cplx_t;
  typedef logic [15:0]        q16_t;
  typedef logic [1:0]         status_t;

  // command codes
  localparam cmd_t CMD_RESET   = 4'd0;
  localparam cmd_t CMD_SET     = 4'd1;
  localparam cmd_t CMD_WRITE   = 4'd2;
  localparam cmd_t CMD_READ    = 4'd3;
  localparam cmd_t CMD_GATE    = 4'd4;
  localparam cmd_t CMD_CGATE   = 4'd5;
  localparam cmd_t CMD_TOFFOLI = 4'd6;
  localparam cmd_t CMD_MEASURE = 4'd7;
  localparam cmd_t CMD_MEASALL = 4'd8;

  // status codes
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_QUBIT = 2'd1;
  localparam status_t STATUS_INDEX = 2'd2;
  localparam status_t STATUS_ZERO  = 2'd3;

  // fixed point
  localparam int FRAC         = 14;
  localparam int SUM_W        = 64;
  localparam int PROB_SHIFT   = 2 * FRAC - 16;
  localparam int RENORM_SHIFT = FRAC + 9;
  localparam int SQRT_STEPS   = 32;
  localparam int DEN_W        = 34;

  // what a probability pass does with each squared magnitude
  typedef enum logic [1:0] {
    SQ_READ = 2'd0,
    SQ_MQ   = 2'd1,
    SQ_TOT  = 2'd2,
    SQ_CUM  = 2'd3
  } sq_mode_t;

endpackage

### rtl/sge_if.sv
interface sge_req_if;
  logic                  valid;
  logic                  ready;
  sge_pkg::cmd_t         cmd;
  sge_pkg::qubit_t       target_qubit;
  sge_pkg::qubit_t       control_one;
  sge_pkg::qubit_t       control_two;
  sge_pkg::index_t       basis_index;
  sge_pkg::q14_t         amp_real;
  sge_pkg::q14_t         amp_imag;
  sge_pkg::cplx_t        gate_m00;
  sge_pkg::cplx_t        gate_m01;
  sge_pkg::cplx_t        gate_m10;
  sge_pkg::cplx_t        gate_m11;
  sge_pkg::q16_t         random_fraction;

  modport source (
    output valid, cmd, target_qubit, control_one, control_two, basis_index,
           amp_real, amp_imag, gate_m00, gate_m01, gate_m10, gate_m11,
           random_fraction,
    input  ready
  );
  modport sink (
    input  valid, cmd, target_qubit, control_one, control_two, basis_index,
           amp_real, amp_imag, gate_m00, gate_m01, gate_m10, gate_m11,
           random_fraction,
    output ready
  );
endinterface

interface sge_rsp_if;
  logic            valid;
  logic            ready;
  sge_pkg::status_t status;
  sge_pkg::index_t outcome;
  sge_pkg::q14_t   read_real;
  sge_pkg::q14_t   read_imag;
  sge_pkg::q16_t   read_prob;

  modport source (
    output valid, status, outcome, read_real, read_imag, read_prob,
    input  ready
  );
  modport sink (
    input  valid, status, outcome, read_real, read_imag, read_prob,
    output ready
  );
endinterface

### rtl/statevector_gate_engine_unit.sv
// channel   dir  handshake     word
// req       in   valid/ready   command, qubits, index, amplitude, matrix, random
// rsp       out  valid/ready   status, outcome, read amplitude, probability
// cfg       in   cfg_we        qubits_in_use, 4 bits
//
// reset, set basis: a clear sweep over all 2^MAX_QUBITS entries;
// gate: a scan of the 2^n entries, with a read, multiply and write per active pair (a swap for toffoli);
// measure qubit: a sum pass, a square root, then dropped entries zeroed and kept entries divided;
// measure all: a total pass, a cumulative pass up to the outcome, then a clear sweep.
// after reset a clear sweep of the whole store runs with req.ready low.
// req.ready is high only when idle; a result waiting in rsp does not block it.
module statevector_gate_engine_unit #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_BITS   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  sge_req_if.sink    req,
  sge_rsp_if.source  rsp
);

  localparam int AW      = MAX_QUBITS;
  localparam int DEPTH   = 1 << AW;
  localparam int NQ_W    = $clog2(MAX_QUBITS + 1);
  localparam int MOP     = ((AMP_BITS > 16) ? AMP_BITS : 16) + 1;
  localparam int PW      = 2 * MOP;
  localparam int ACC_W   = PW + 2;
  localparam int NUM_W   = AMP_BITS + 26;
  localparam int MAG_W   = NUM_W - 1;
  localparam int DC_W    = $clog2(MAG_W);
  localparam int SAT_W   = (ACC_W > NUM_W + 1) ? ACC_W : NUM_W + 1;
  localparam int W_W     = 2 * AMP_BITS;
  localparam longint AMP_HI = (longint'(1) << (AMP_BITS - 1)) - 1;
  localparam longint ONE_L  = (AMP_BITS > sge_pkg::FRAC + 1) ?
                              (longint'(1) << sge_pkg::FRAC) : AMP_HI;
  localparam logic signed [AMP_BITS-1:0] ONE_S = AMP_BITS'(ONE_L);

  typedef enum logic [22:0] {
    IDLE      = 23'h000001,
    CLEAR     = 23'h000002,
    SQ_RD     = 23'h000004,
    SQ_RE     = 23'h000008,
    SQ_IM     = 23'h000010,
    SQ_ACC    = 23'h000020,
    MQ_DECIDE = 23'h000040,
    SQRT      = 23'h000080,
    RN_RD     = 23'h000100,
    RN_LD     = 23'h000200,
    DIV_LD    = 23'h000400,
    DIV       = 23'h000800,
    RN_WR     = 23'h001000,
    THR       = 23'h002000,
    G_SCAN    = 23'h004000,
    G_RD1     = 23'h008000,
    G_RD2     = 23'h010000,
    G_MAC     = 23'h020000,
    G_WR0     = 23'h040000,
    G_WR1     = 23'h080000,
    T_WR0     = 23'h100000,
    T_WR1     = 23'h200000,
    FINISH    = 23'h400000
  } state_t;

  function automatic logic signed [AMP_BITS-1:0] sat_amp(
    input logic signed [SAT_W-1:0] v
  );
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    logic signed [AMP_BITS-1:0] r;
    hi = SAT_W'(AMP_HI);
    lo = -hi - SAT_W'(1);
    if (v > hi) r = AMP_BITS'(hi);
    else if (v < lo) r = AMP_BITS'(lo);
    else r = AMP_BITS'(v);
    return r;
  endfunction

  function automatic logic signed [AMP_BITS-1:0] round_q14(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] t;
    t = (v + (ACC_W'(1) <<< (sge_pkg::FRAC - 1))) >>> sge_pkg::FRAC;
    return sat_amp(SAT_W'(t));
  endfunction

  state_t state;
  sge_pkg::sq_mode_t mode;
  logic [AW-1:0] pos, one_idx;
  logic boot;
  logic [3:0] qubits;

  // latched command
  sge_pkg::cmd_t cmd_r;
  logic [3:0] tq_r, c1_r, c2_r;
  logic [31:0] m_r [4];
  logic [15:0] rnd_r;

  // pending result and output register
  sge_pkg::status_t st_r, o_status;
  logic [9:0] oc_r, o_outcome;
  logic [15:0] rr_r, ri_r, rp_r, o_real, o_imag, o_prob;
  logic o_valid;

  // amplitude store
  logic [W_W-1:0] mem [DEPTH];
  logic [W_W-1:0] rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic we;
  logic signed [AMP_BITS-1:0] rd_re, rd_im;

  // shared multiplier
  logic signed [MOP-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  // datapath registers
  logic signed [AMP_BITS-1:0] a_re, a_im, b_re, b_im, q_re, q_im;
  logic signed [ACC_W-1:0] acc [4];
  logic [4:0] s;
  logic [sge_pkg::SUM_W-1:0] sum0, sum1, thr, thr_acc, mag_lo;
  logic meas_bit;
  logic [63:0] sq_x, sq_res;
  logic [4:0] sq_k;
  logic [32:0] r_reg;
  logic [MAG_W-1:0] dq;
  logic [sge_pkg::DEN_W-1:0] rem;
  logic dneg, div_sel;
  logic [DC_W-1:0] dcnt;

  // derived control
  logic [NQ_W-1:0] nq;
  logic [AW-1:0] size_m1, tmask, c1mask, c2mask;
  logic last, fire, idx_bad, q_bad, wr_ok;

  assign rd_re = rdata[W_W-1 -: AMP_BITS];
  assign rd_im = rdata[AMP_BITS-1:0];

  // active qubit count, clamped
  always_comb begin
    if (qubits == 4'd0) nq = NQ_W'(1);
    else if (int'(qubits) > MAX_QUBITS) nq = NQ_W'(MAX_QUBITS);
    else nq = NQ_W'(qubits);
  end

  assign size_m1 = AW'((((AW + 1)'(1)) << nq) - (AW + 1)'(1));
  assign last    = (pos == size_m1);
  assign tmask   = AW'(1) << tq_r;
  assign c1mask  = AW'(1) << c1_r;
  assign c2mask  = AW'(1) << c2_r;

  // command checks at the input
  assign fire    = req.valid && req.ready;
  assign idx_bad = (req.cmd inside {[sge_pkg::CMD_SET:sge_pkg::CMD_READ]}) &&
                   ((32'(req.basis_index) >> nq) != 32'd0);
  always_comb begin
    q_bad = 1'b0;
    if ((req.cmd inside {[sge_pkg::CMD_GATE:sge_pkg::CMD_MEASURE]}) &&
        (32'(req.target_qubit) >= 32'(nq)))
      q_bad = 1'b1;
    if ((req.cmd == sge_pkg::CMD_CGATE || req.cmd == sge_pkg::CMD_TOFFOLI) &&
        (32'(req.control_one) >= 32'(nq)))
      q_bad = 1'b1;
    if ((req.cmd == sge_pkg::CMD_TOFFOLI) && (32'(req.control_two) >= 32'(nq)))
      q_bad = 1'b1;
  end
  assign wr_ok = fire && (req.cmd == sge_pkg::CMD_WRITE) && !idx_bad;

  // squared magnitude of the entry in flight
  logic [63:0] mag, sum0_n, sum1_n, prob_n;
  assign mag    = mag_lo + 64'(prod);
  assign sum0_n = sum0 + mag;
  assign sum1_n = sum1 + mag;
  assign prob_n = (mag + (64'(1) << (sge_pkg::PROB_SHIFT - 1))) >> sge_pkg::PROB_SHIFT;

  // gate mac step decode
  logic [4:0] sm1;
  logic [1:0] mk, mt;
  logic mneg;
  logic [31:0] m_sel;
  assign sm1  = s - 5'd1;
  assign mk   = sm1[3:2];
  assign mt   = sm1[1:0];
  assign mneg = !mk[0] && mt[0];
  logic [1:0] ik, it;
  assign ik    = s[3:2];
  assign it    = s[1:0];
  assign m_sel = m_r[{ik[1], it[1]}];

  // thresholds for measure all
  logic [63:0] thr_acc_n;
  assign thr_acc_n = thr_acc + (64'(prod) << {sm1[1:0], 4'b0});

  // square root step
  logic [63:0] sq_bit, sq_trial, sq_x_n, sq_res_n;
  logic sq_take;
  assign sq_bit   = 64'(1) << {sq_k, 1'b0};
  assign sq_trial = sq_res + sq_bit;
  assign sq_take  = sq_x >= sq_trial;
  assign sq_x_n   = sq_take ? sq_x - sq_trial : sq_x;
  assign sq_res_n = sq_take ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  // divider: load and restoring step
  logic signed [AMP_BITS-1:0] div_src;
  logic signed [NUM_W-1:0] num_s, num_abs;
  logic [sge_pkg::DEN_W-1:0] den;
  logic [sge_pkg::DEN_W:0] rem_sh, rem_sub;
  logic ge;
  logic [sge_pkg::DEN_W-1:0] rem_n;
  logic [MAG_W-1:0] dq_n;
  logic [MAG_W:0] qmag;
  logic signed [SAT_W-1:0] qpos, qval;
  logic signed [AMP_BITS-1:0] qsat;
  assign div_src = div_sel ? a_im : a_re;
  assign num_s   = (NUM_W'(div_src) <<< sge_pkg::RENORM_SHIFT) + NUM_W'(r_reg);
  assign num_abs = num_s[NUM_W-1] ? -num_s : num_s;
  assign den     = {r_reg, 1'b0};
  assign rem_sh  = {rem, dq[MAG_W-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};
  assign rem_n   = ge ? rem_sub[sge_pkg::DEN_W-1:0] : rem_sh[sge_pkg::DEN_W-1:0];
  assign dq_n    = {dq[MAG_W-2:0], ge};
  assign qmag    = (MAG_W + 1)'(dq_n) + (MAG_W + 1)'(dneg && (rem_n != '0));
  assign qpos    = SAT_W'(qmag);
  assign qval    = dneg ? -qpos : qpos;
  assign qsat    = sat_amp(qval);

  logic keep;
  assign keep = ((pos & tmask) != '0) == meas_bit;

  logic gate_ok;
  assign gate_ok = ((pos & tmask) == '0) &&
                   ((cmd_r == sge_pkg::CMD_GATE) || ((pos & c1mask) != '0)) &&
                   ((cmd_r != sge_pkg::CMD_TOFFOLI) || ((pos & c2mask) != '0));

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = '0;
    raddr = (state == G_RD1) ? (pos | tmask) : pos;
    case (state)
      IDLE: begin
        if (wr_ok) begin
          we    = 1'b1;
          waddr = AW'(req.basis_index);
          wdata = {sat_amp(SAT_W'(req.amp_real)), sat_amp(SAT_W'(req.amp_imag))};
        end
      end
      CLEAR: begin
        we    = 1'b1;
        wdata = (pos == one_idx) ? {ONE_S, AMP_BITS'(0)} : '0;
      end
      RN_LD: we = !keep;
      RN_WR: begin
        we    = 1'b1;
        wdata = {q_re, q_im};
      end
      G_WR0: begin
        we    = 1'b1;
        wdata = {round_q14(acc[0]), round_q14(acc[1])};
      end
      G_WR1: begin
        we    = 1'b1;
        waddr = pos | tmask;
        wdata = {round_q14(acc[2]), round_q14(acc[3])};
      end
      T_WR0: begin
        we    = 1'b1;
        wdata = {b_re, b_im};
      end
      T_WR1: begin
        we    = 1'b1;
        waddr = pos | tmask;
        wdata = {a_re, a_im};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      SQ_RE: begin
        mul_a = MOP'(rd_re);
        mul_b = MOP'(rd_re);
      end
      SQ_IM: begin
        mul_a = MOP'(rd_im);
        mul_b = MOP'(rd_im);
      end
      THR: begin
        mul_a = MOP'($signed({1'b0, rnd_r}));
        mul_b = MOP'($signed({1'b0, sum0[{s[1:0], 4'b0} +: 16]}));
      end
      G_MAC: begin
        mul_a = it[0] ? MOP'($signed(m_sel[15:0])) : MOP'($signed(m_sel[31:16]));
        if (it[1]) mul_b = (it[0] ^ ik[0]) ? MOP'(b_im) : MOP'(b_re);
        else       mul_b = (it[0] ^ ik[0]) ? MOP'(a_im) : MOP'(a_re);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  assign req.ready     = (state == IDLE);
  assign rsp.valid     = o_valid;
  assign rsp.status    = o_status;
  assign rsp.outcome   = o_outcome;
  assign rsp.read_real = o_real;
  assign rsp.read_imag = o_imag;
  assign rsp.read_prob = o_prob;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) qubits <= 4'd10;
    else if (cfg_we) qubits <= cfg_wdata;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= CLEAR;
      pos     <= '0;
      one_idx <= '0;
      boot    <= 1'b1;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && rsp.ready && state != FINISH) o_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (fire) begin
            cmd_r   <= req.cmd;
            tq_r    <= req.target_qubit;
            c1_r    <= req.control_one;
            c2_r    <= req.control_two;
            m_r[0]  <= req.gate_m00;
            m_r[1]  <= req.gate_m01;
            m_r[2]  <= req.gate_m10;
            m_r[3]  <= req.gate_m11;
            rnd_r   <= req.random_fraction;
            oc_r    <= '0;
            rr_r    <= '0;
            ri_r    <= '0;
            rp_r    <= '0;
            pos     <= (req.cmd == sge_pkg::CMD_READ) ? AW'(req.basis_index) : '0;
            sum0    <= '0;
            sum1    <= '0;
            if (idx_bad) begin
              st_r  <= sge_pkg::STATUS_INDEX;
              state <= FINISH;
            end else if (q_bad) begin
              st_r  <= sge_pkg::STATUS_QUBIT;
              state <= FINISH;
            end else begin
              st_r <= sge_pkg::STATUS_OK;
              case (req.cmd)
                sge_pkg::CMD_RESET: begin
                  one_idx <= '0;
                  state   <= CLEAR;
                end
                sge_pkg::CMD_SET: begin
                  one_idx <= AW'(req.basis_index);
                  state   <= CLEAR;
                end
                sge_pkg::CMD_READ: begin
                  mode  <= sge_pkg::SQ_READ;
                  state <= SQ_RD;
                end
                sge_pkg::CMD_GATE, sge_pkg::CMD_CGATE, sge_pkg::CMD_TOFFOLI:
                  state <= G_SCAN;
                sge_pkg::CMD_MEASURE: begin
                  mode  <= sge_pkg::SQ_MQ;
                  state <= SQ_RD;
                end
                sge_pkg::CMD_MEASALL: begin
                  mode  <= sge_pkg::SQ_TOT;
                  state <= SQ_RD;
                end
                default: state <= FINISH;
              endcase
            end
          end
        end

        // sweep the whole store, one entry set to one
        CLEAR: begin
          if (&pos) begin
            boot  <= 1'b0;
            state <= boot ? IDLE : FINISH;
          end else begin
            pos <= pos + AW'(1);
          end
        end

        // squared magnitude of one entry
        SQ_RD: state <= SQ_RE;
        SQ_RE: state <= SQ_IM;
        SQ_IM: begin
          mag_lo <= 64'(prod);
          state  <= SQ_ACC;
        end
        SQ_ACC: begin
          case (mode)
            sge_pkg::SQ_READ: begin
              rr_r  <= 16'(rd_re);
              ri_r  <= 16'(rd_im);
              rp_r  <= (prob_n[63:16] != '0) ? 16'hFFFF : prob_n[15:0];
              state <= FINISH;
            end
            sge_pkg::SQ_MQ: begin
              if ((pos & tmask) != '0) sum1 <= sum1_n;
              else sum0 <= sum0_n;
              if (last) begin
                state <= MQ_DECIDE;
              end else begin
                pos   <= pos + AW'(1);
                state <= SQ_RD;
              end
            end
            sge_pkg::SQ_TOT: begin
              sum0 <= sum0_n;
              if (last) begin
                if (sum0_n == '0) begin
                  st_r  <= sge_pkg::STATUS_ZERO;
                  state <= FINISH;
                end else begin
                  s       <= '0;
                  thr_acc <= '0;
                  state   <= THR;
                end
              end else begin
                pos   <= pos + AW'(1);
                state <= SQ_RD;
              end
            end
            default: begin
              sum1 <= sum1_n;
              if (sum1_n > thr) begin
                one_idx <= pos;
                oc_r    <= 10'(pos);
                pos     <= '0;
                state   <= CLEAR;
              end else if (last) begin
                one_idx <= size_m1;
                oc_r    <= 10'(size_m1);
                pos     <= '0;
                state   <= CLEAR;
              end else begin
                pos   <= pos + AW'(1);
                state <= SQ_RD;
              end
            end
          endcase
        end

        // threshold = random fraction times total, four 16-bit slices
        THR: begin
          if (s != 5'd0) thr_acc <= thr_acc_n;
          if (s == 5'd4) begin
            thr   <= thr_acc_n >> 16;
            pos   <= '0;
            sum1  <= '0;
            mode  <= sge_pkg::SQ_CUM;
            state <= SQ_RD;
          end else begin
            s <= s + 5'd1;
          end
        end

        // pick the outcome and start the square root
        MQ_DECIDE: begin
          if ((64'(rnd_r) << sge_pkg::PROB_SHIFT) < sum1) begin
            meas_bit <= 1'b1;
            oc_r     <= 10'd1;
            sq_x     <= sum1 << 16;
            if (sum1 == '0) begin
              st_r  <= sge_pkg::STATUS_ZERO;
              state <= FINISH;
            end else begin
              state <= SQRT;
            end
          end else begin
            meas_bit <= 1'b0;
            oc_r     <= 10'd0;
            sq_x     <= sum0 << 16;
            if (sum0 == '0) begin
              st_r  <= sge_pkg::STATUS_ZERO;
              state <= FINISH;
            end else begin
              state <= SQRT;
            end
          end
          sq_res <= '0;
          sq_k   <= 5'(sge_pkg::SQRT_STEPS - 1);
        end

        // one result bit per cycle
        SQRT: begin
          sq_x   <= sq_x_n;
          sq_res <= sq_res_n;
          if (sq_k == 5'd0) begin
            r_reg <= (sq_res_n == '0) ? 33'd1 : 33'(sq_res_n);
            pos   <= '0;
            state <= RN_RD;
          end else begin
            sq_k <= sq_k - 5'd1;
          end
        end

        // renormalize pass
        RN_RD: state <= RN_LD;
        RN_LD: begin
          if (!keep) begin
            if (last) state <= FINISH;
            else begin
              pos   <= pos + AW'(1);
              state <= RN_RD;
            end
          end else begin
            a_re    <= rd_re;
            a_im    <= rd_im;
            div_sel <= 1'b0;
            state   <= DIV_LD;
          end
        end
        DIV_LD: begin
          dq    <= num_abs[MAG_W-1:0];
          dneg  <= num_s[NUM_W-1];
          rem   <= '0;
          dcnt  <= DC_W'(MAG_W - 1);
          state <= DIV;
        end
        DIV: begin
          dq  <= dq_n;
          rem <= rem_n;
          if (dcnt == '0) begin
            if (!div_sel) begin
              q_re    <= qsat;
              div_sel <= 1'b1;
              state   <= DIV_LD;
            end else begin
              q_im  <= qsat;
              state <= RN_WR;
            end
          end else begin
            dcnt <= dcnt - DC_W'(1);
          end
        end
        RN_WR: begin
          if (last) state <= FINISH;
          else begin
            pos   <= pos + AW'(1);
            state <= RN_RD;
          end
        end

        // gate pair walk
        G_SCAN: begin
          if (gate_ok) state <= G_RD1;
          else if (last) state <= FINISH;
          else pos <= pos + AW'(1);
        end
        G_RD1: begin
          a_re  <= rd_re;
          a_im  <= rd_im;
          state <= G_RD2;
        end
        G_RD2: begin
          b_re <= rd_re;
          b_im <= rd_im;
          if (cmd_r == sge_pkg::CMD_TOFFOLI) begin
            state <= T_WR0;
          end else begin
            s      <= '0;
            acc[0] <= '0;
            acc[1] <= '0;
            acc[2] <= '0;
            acc[3] <= '0;
            state  <= G_MAC;
          end
        end
        G_MAC: begin
          if (s != 5'd0)
            acc[mk] <= acc[mk] + (mneg ? -ACC_W'(prod) : ACC_W'(prod));
          if (s == 5'd16) state <= G_WR0;
          else s <= s + 5'd1;
        end
        G_WR0: state <= G_WR1;
        T_WR0: state <= T_WR1;
        G_WR1, T_WR1: begin
          if (last) state <= FINISH;
          else begin
            pos   <= pos + AW'(1);
            state <= G_SCAN;
          end
        end

        // hand the word to the output register
        FINISH: begin
          if (!o_valid || rsp.ready) begin
            o_valid   <= 1'b1;
            o_status  <= st_r;
            o_outcome <= oc_r;
            o_real    <= rr_r;
            o_imag    <= ri_r;
            o_prob    <= rp_r;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
